@@ src/p2p_pid_pkg.sv @@
// Shared constants and types for the point-to-point PID controller.
// Field widths, register reset values and register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package p2p_pid_pkg;

  localparam int unsigned PosW   = 24;  // position field width
  localparam int unsigned ErrW   = 25;  // position error width
  localparam int unsigned DdW    = 27;  // second error difference width
  localparam int unsigned RegW   = 16;  // configuration register width
  localparam int unsigned DriveW = 17;  // drive output width
  localparam int unsigned FracW  = 12;  // gain fraction bits
  localparam int unsigned SqW    = 48;  // one squared error component
  localparam int unsigned D2W    = 50;  // sum of three squares
  localparam int unsigned R2W    = 32;  // squared radius
  localparam int unsigned P1W    = 42;  // (gain_p + gain_i) * error
  localparam int unsigned P2W    = 43;  // gain_d * second difference
  localparam int unsigned SumW   = 45;  // rounded sum of both products
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned InDataW  = 6 * PosW;   // 144 bits, whole bytes
  localparam int unsigned OutDataW = 40;         // 35 bits of fields, padded

  localparam logic [RegW-1:0] GainPRst  = 16'd410;
  localparam logic [RegW-1:0] GainIRst  = 16'd205;
  localparam logic [RegW-1:0] GainDRst  = 16'd0;
  localparam logic [RegW-1:0] LimitRst  = 16'd3840;
  localparam logic [RegW-1:0] RadiusRst = 16'd2560;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_OUTPUT_LIMIT = 3'd3,
    CFG_NEAR_RADIUS  = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ src/point_to_point_pid_with_arrival.sv @@
// Point-to-point PID position controller with arrival test (top level).
// Three register stages (errors, products, result) lie between the slave and master sides.
// Throughput: one beat per cycle while the master side does not stall.
// The stages hand over through per-stage valid bits, so bubbles close up under stall.
// Reset: asynchronous, active low; clears the error history and valid bits and
// loads the gain, limit and radius registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module point_to_point_pid_with_arrival (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [p2p_pid_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [p2p_pid_pkg::RegW-1:0]         cfg_wdata_i,
  // slave side
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // present_x, present_y, present_z, target_x, target_y, target_z (24 bits each)
  input  wire logic [p2p_pid_pkg::InDataW-1:0]      s_axis_tdata,
  // master side
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // drive_x [16:0], drive_y [33:17], holding [34], zero padding [39:35]
  output      logic [p2p_pid_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned PosW   = p2p_pid_pkg::PosW;
  localparam int unsigned ErrW   = p2p_pid_pkg::ErrW;
  localparam int unsigned DdW    = p2p_pid_pkg::DdW;
  localparam int unsigned RegW   = p2p_pid_pkg::RegW;
  localparam int unsigned DriveW = p2p_pid_pkg::DriveW;
  localparam int unsigned FracW  = p2p_pid_pkg::FracW;
  localparam int unsigned SqW    = p2p_pid_pkg::SqW;
  localparam int unsigned D2W    = p2p_pid_pkg::D2W;
  localparam int unsigned R2W    = p2p_pid_pkg::R2W;
  localparam int unsigned P1W    = p2p_pid_pkg::P1W;
  localparam int unsigned P2W    = p2p_pid_pkg::P2W;
  localparam int unsigned SumW   = p2p_pid_pkg::SumW;
  localparam int unsigned ShW    = SumW - FracW;
  localparam int unsigned MulW   = 50;

  // ---------------------------------------------------------------- config
  logic [RegW-1:0] gain_p_q, gain_i_q, gain_d_q, limit_q, radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= p2p_pid_pkg::GainPRst;
      gain_i_q <= p2p_pid_pkg::GainIRst;
      gain_d_q <= p2p_pid_pkg::GainDRst;
      limit_q  <= p2p_pid_pkg::LimitRst;
      radius_q <= p2p_pid_pkg::RadiusRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        p2p_pid_pkg::CFG_GAIN_P:       gain_p_q <= cfg_wdata_i;
        p2p_pid_pkg::CFG_GAIN_I:       gain_i_q <= cfg_wdata_i;
        p2p_pid_pkg::CFG_GAIN_D:       gain_d_q <= cfg_wdata_i;
        p2p_pid_pkg::CFG_OUTPUT_LIMIT: limit_q  <= cfg_wdata_i;
        p2p_pid_pkg::CFG_NEAR_RADIUS:  radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_acc;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v3_q;
  assign in_acc        = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Errors and second differences; the history shifts on every accepted beat.
  logic signed [PosW-1:0] px, py, pz, tx, ty, tz;
  logic signed [ErrW-1:0] ex_d, ey_d, ez_d;
  logic signed [DdW-1:0]  ddx_d, ddy_d;
  logic signed [ErrW-1:0] x_last_q, x_before_q, y_last_q, y_before_q;
  logic signed [ErrW-1:0] ex_q, ey_q, ez_q;
  logic signed [DdW-1:0]  ddx_q, ddy_q;

  assign px = s_axis_tdata[0*PosW +: PosW];
  assign py = s_axis_tdata[1*PosW +: PosW];
  assign pz = s_axis_tdata[2*PosW +: PosW];
  assign tx = s_axis_tdata[3*PosW +: PosW];
  assign ty = s_axis_tdata[4*PosW +: PosW];
  assign tz = s_axis_tdata[5*PosW +: PosW];

  always_comb begin
    ex_d  = ErrW'(tx) - ErrW'(px);
    ey_d  = ErrW'(ty) - ErrW'(py);
    ez_d  = ErrW'(tz) - ErrW'(pz);
    ddx_d = DdW'(ex_d) - (DdW'(x_last_q) <<< 1) + DdW'(x_before_q);
    ddy_d = DdW'(ey_d) - (DdW'(y_last_q) <<< 1) + DdW'(y_before_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_last_q   <= '0;
      x_before_q <= '0;
      y_last_q   <= '0;
      y_before_q <= '0;
    end else if (in_acc) begin
      x_last_q   <= ex_d;
      x_before_q <= x_last_q;
      y_last_q   <= ey_d;
      y_before_q <= y_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      ez_q  <= ez_d;
      ddx_q <= ddx_d;
      ddy_q <= ddy_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // One multiplier per product, each registered before it is summed.
  logic signed [MulW-1:0] gsum, gd, mx1, my1, mx2, my2, sqx, sqy, sqz;
  logic signed [P1W-1:0]  px1_q, py1_q;
  logic signed [P2W-1:0]  px2_q, py2_q;
  logic [SqW-1:0]         sqx_q, sqy_q, sqz_q;
  logic [R2W-1:0]         r2_q;

  always_comb begin
    // Two extra bits keep the carry of the gain sum at full scale.
    gsum = MulW'($signed({2'b00, gain_p_q}) + $signed({2'b00, gain_i_q}));
    gd   = MulW'($signed({1'b0, gain_d_q}));
    mx1  = gsum * MulW'(ex_q);
    my1  = gsum * MulW'(ey_q);
    mx2  = gd * MulW'(ddx_q);
    my2  = gd * MulW'(ddy_q);
    sqx  = MulW'(ex_q) * MulW'(ex_q);
    sqy  = MulW'(ey_q) * MulW'(ey_q);
    sqz  = MulW'(ez_q) * MulW'(ez_q);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      px1_q <= mx1[P1W-1:0];
      py1_q <= my1[P1W-1:0];
      px2_q <= mx2[P2W-1:0];
      py2_q <= my2[P2W-1:0];
      sqx_q <= sqx[SqW-1:0];
      sqy_q <= sqy[SqW-1:0];
      sqz_q <= sqz[SqW-1:0];
      r2_q  <= R2W'(radius_q) * R2W'(radius_q);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Round half up from Q.12 to whole units, clamp to the limit, and test the arrival radius.
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [ShW-1:0]    shx, shy, lim_pos, lim_neg;
  logic signed [DriveW-1:0] drv_x_d, drv_y_d;
  logic [D2W-1:0]           d2;
  logic                     hold_d;
  logic [DriveW-1:0]        drv_x_q, drv_y_q;
  logic                     hold_q;

  always_comb begin
    sum_x   = SumW'(px1_q) + SumW'(px2_q) + SumW'(2 ** (FracW - 1));
    sum_y   = SumW'(py1_q) + SumW'(py2_q) + SumW'(2 ** (FracW - 1));
    shx     = ShW'(sum_x >>> FracW);
    shy     = ShW'(sum_y >>> FracW);
    lim_pos = $signed(ShW'(limit_q));
    lim_neg = -lim_pos;

    priority if (shx > lim_pos) drv_x_d = DriveW'(lim_pos);
    else if (shx < lim_neg)      drv_x_d = DriveW'(lim_neg);
    else                         drv_x_d = DriveW'(shx);

    priority if (shy > lim_pos) drv_y_d = DriveW'(lim_pos);
    else if (shy < lim_neg)      drv_y_d = DriveW'(lim_neg);
    else                         drv_y_d = DriveW'(shy);

    d2     = D2W'(sqx_q) + D2W'(sqy_q) + D2W'(sqz_q);
    hold_d = d2 < D2W'(r2_q);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      drv_x_q <= drv_x_d;
      drv_y_q <= drv_y_d;
      hold_q  <= hold_d;
    end
  end

  assign m_axis_tdata = {
    {(p2p_pid_pkg::OutDataW - 2 * DriveW - 1){1'b0}}, hold_q, drv_y_q, drv_x_q
  };

endmodule

`default_nettype wire

@@ bench/point_to_point_pid_with_arrival_tb.sv @@
// Self-checking bench for point_to_point_pid_with_arrival: a directed table, then random
// control ticks under varied gains, limits and flow control, checked by a PID predictor.
// Depends on p2p_pid_pkg and the top-level RTL only.
`timescale 1ns / 1ps
module point_to_point_pid_with_arrival_tb;

  localparam int unsigned CfgIdxW  = p2p_pid_pkg::CfgIdxW;
  localparam int unsigned PosW     = p2p_pid_pkg::PosW;
  localparam int unsigned ErrW     = p2p_pid_pkg::ErrW;
  localparam int unsigned RegW     = p2p_pid_pkg::RegW;
  localparam int unsigned DriveW   = p2p_pid_pkg::DriveW;
  localparam int unsigned FracW    = p2p_pid_pkg::FracW;
  localparam int unsigned InDataW  = p2p_pid_pkg::InDataW;
  localparam int unsigned OutDataW = p2p_pid_pkg::OutDataW;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseTicks = 210;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned NumDirRows = 25;
  localparam int unsigned TailCycles = 10;

  // An index beyond the register map; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd6;

  localparam logic signed [PosW-1:0] PosMin = 24'sh800000;
  localparam logic signed [PosW-1:0] PosMax = 24'sh7FFFFF;

  typedef struct packed {
    logic signed [PosW-1:0] px, py, pz, tx, ty, tz;
  } tick_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_x;
    logic signed [DriveW-1:0] drive_y;
    logic                     holding;
  } drive_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [RegW-1:0]    val;
    tick_t              tick;
    logic               known;
    drive_t             want;
  } row_t;

  localparam tick_t  TickZero = '0;
  localparam tick_t  TickRise = '{PosMin, PosMin, PosMin, PosMax, PosMax, PosMax};
  localparam tick_t  TickFall = '{PosMax, PosMax, PosMax, PosMin, PosMin, PosMin};
  localparam drive_t NoDrive  = '0;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [RegW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;

  point_to_point_pid_with_arrival dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Controller registers and error history as the block should hold them.
  logic [RegW-1:0]        kp_r     = p2p_pid_pkg::GainPRst;
  logic [RegW-1:0]        ki_r     = p2p_pid_pkg::GainIRst;
  logic [RegW-1:0]        kd_r     = p2p_pid_pkg::GainDRst;
  logic [RegW-1:0]        limit_r  = p2p_pid_pkg::LimitRst;
  logic [RegW-1:0]        radius_r = p2p_pid_pkg::RadiusRst;
  logic signed [ErrW-1:0] x_hist1  = '0;
  logic signed [ErrW-1:0] x_hist2  = '0;
  logic signed [ErrW-1:0] y_hist1  = '0;
  logic signed [ErrW-1:0] y_hist2  = '0;

  drive_t pending_drives [$];

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  int unsigned ticks_sent    = 0;
  int unsigned reg_writes    = 0;
  int unsigned results_seen  = 0;
  int unsigned holds_seen    = 0;
  int unsigned mismatches    = 0;

  // Trajectory state: a target with an offset that shrinks tick by tick.
  int trk_tx, trk_ty, trk_tz, off_x, off_y, off_z;
  int trk_left = 0;

  row_t dir_rows [NumDirRows] = '{
    // all zero: no error, and well inside the arrival radius
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickZero, 1'b1,
      '{17'sd0, 17'sd0, 1'b1}},
    // widest errors either way, clamped at the default limit
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickRise, 1'b1,
      '{17'sd3840, 17'sd3840, 1'b0}},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickFall, 1'b1,
      '{-17'sd3840, -17'sd3840, 1'b0}},
    // one below the radius, then exactly on it
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{24'sd0, 24'sd0, 24'sd0, 24'sd2559, 24'sd0, 24'sd0}, 1'b0, NoDrive},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{24'sd0, 24'sd0, 24'sd0, 24'sd2560, 24'sd0, 24'sd0}, 1'b0, NoDrive},
    // holding tick with error on all three axes; the history still moves on
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{-24'sd1000, 24'sd1000, 24'sd0, 24'sd0, 24'sd0, -24'sd2000}, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_D, 16'hFFFF, TickZero, 1'b0, NoDrive},
    // step in and out with the largest derivative gain
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{24'sd0, 24'sd0, 24'sd0, -24'sd256, 24'sd256, 24'sd0}, 1'b0, NoDrive},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{24'sd0, 24'sd0, 24'sd0, -24'sd256, 24'sd256, 24'sd0}, 1'b0, NoDrive},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickZero, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickZero, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_I, 16'd0, TickZero, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_D, 16'd0, TickZero, 1'b0, NoDrive},
    // no gain at all gives no drive
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickRise, 1'b1,
      '{17'sd0, 17'sd0, 1'b0}},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_P, 16'hFFFF, TickZero, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_GAIN_I, 16'hFFFF, TickZero, 1'b0, NoDrive},
    '{ROW_WRITE, p2p_pid_pkg::CFG_OUTPUT_LIMIT, 16'hFFFF, TickZero, 1'b0, NoDrive},
    // largest gains and largest clamp
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickRise, 1'b1,
      '{17'sd65535, 17'sd65535, 1'b0}},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickFall, 1'b1,
      '{-17'sd65535, -17'sd65535, 1'b0}},
    '{ROW_WRITE, p2p_pid_pkg::CFG_OUTPUT_LIMIT, 16'd0, TickZero, 1'b0, NoDrive},
    // a zero clamp forces both drives to zero
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0,
      '{24'sd0, 24'sd0, 24'sd0, 24'sd1000, -24'sd1000, 24'sd0}, 1'b1,
      '{17'sd0, 17'sd0, 1'b1}},
    '{ROW_WRITE, p2p_pid_pkg::CFG_NEAR_RADIUS, 16'd0, TickZero, 1'b0, NoDrive},
    // a zero radius never reports holding, not even at zero distance
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickZero, 1'b1,
      '{17'sd0, 17'sd0, 1'b0}},
    '{ROW_WRITE, CfgIdxSpare, 16'hFFFF, TickZero, 1'b0, NoDrive},
    '{ROW_TICK, p2p_pid_pkg::CFG_GAIN_P, 16'd0, TickZero, 1'b1,
      '{17'sd0, 17'sd0, 1'b0}}
  };

  function automatic logic signed [DriveW-1:0] axis_drive(
    input longint                  err,
    inout logic signed [ErrW-1:0]  prev1,
    inout logic signed [ErrW-1:0]  prev2
  );
    longint dd, acc, drv, lim;
    dd  = err - 2 * longint'(prev1) + longint'(prev2);
    acc = (longint'(kp_r) + longint'(ki_r)) * err + longint'(kd_r) * dd;
    // Round half up from Q.12 back to whole units.
    drv = (acc + (64'sd1 <<< (FracW - 1))) >>> FracW;
    lim = longint'(limit_r);
    prev2 = prev1;
    prev1 = ErrW'(err);
    if (drv > lim) drv = lim;
    else if (drv < -lim) drv = -lim;
    return DriveW'(drv);
  endfunction

  function automatic drive_t predict_drive(input tick_t t);
    drive_t r;
    longint ex, ey, ez, dist2, rad2;
    ex    = longint'(t.tx) - longint'(t.px);
    ey    = longint'(t.ty) - longint'(t.py);
    ez    = longint'(t.tz) - longint'(t.pz);
    dist2 = ex * ex + ey * ey + ez * ez;
    rad2  = longint'(radius_r) * longint'(radius_r);
    r.holding = (dist2 < rad2);
    r.drive_x = axis_drive(ex, x_hist1, x_hist2);
    r.drive_y = axis_drive(ey, y_hist1, y_hist2);
    return r;
  endfunction

  function automatic logic [RegW-1:0] pick_reg();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return RegW'($urandom());
    endcase
  endfunction

  // Mostly a craft closing in on its target, now and then an arbitrary tick.
  function automatic tick_t random_tick();
    tick_t t;
    int    span;
    if ($urandom_range(7) == 0) begin
      t.px = PosW'($urandom());
      t.py = PosW'($urandom());
      t.pz = PosW'($urandom());
      t.tx = PosW'($urandom());
      t.ty = PosW'($urandom());
      t.tz = PosW'($urandom());
      return t;
    end
    if (trk_left == 0) begin
      case ($urandom_range(2))
        0: span = 256;
        1: span = 8192;
        default: span = 1 << 20;
      endcase
      trk_tx   = int'($urandom_range(1 << 23)) - (1 << 22);
      trk_ty   = int'($urandom_range(1 << 23)) - (1 << 22);
      trk_tz   = int'($urandom_range(1 << 23)) - (1 << 22);
      off_x    = int'($urandom_range(2 * span)) - span;
      off_y    = int'($urandom_range(2 * span)) - span;
      off_z    = int'($urandom_range(2 * span)) - span;
      trk_left = $urandom_range(40, 10);
    end
    trk_left--;
    t.tx = PosW'(trk_tx);
    t.ty = PosW'(trk_ty);
    t.tz = PosW'(trk_tz);
    t.px = PosW'(trk_tx - off_x);
    t.py = PosW'(trk_ty - off_y);
    t.pz = PosW'(trk_tz - off_z);
    off_x = off_x * 3 / 4 + int'($urandom_range(16)) - 8;
    off_y = off_y * 3 / 4 + int'($urandom_range(16)) - 8;
    off_z = off_z * 3 / 4 + int'($urandom_range(16)) - 8;
    return t;
  endfunction

  // Only called with the block idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (p2p_pid_pkg::cfg_idx_e'(idx))
      p2p_pid_pkg::CFG_GAIN_P:       kp_r     = val;
      p2p_pid_pkg::CFG_GAIN_I:       ki_r     = val;
      p2p_pid_pkg::CFG_GAIN_D:       kd_r     = val;
      p2p_pid_pkg::CFG_OUTPUT_LIMIT: limit_r  = val;
      p2p_pid_pkg::CFG_NEAR_RADIUS:  radius_r = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic offer_tick(input tick_t t, input logic known, input drive_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {t.tz, t.ty, t.tx, t.pz, t.py, t.px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (known) begin
      void'(predict_drive(t));
      pending_drives.push_back(want);
    end else begin
      pending_drives.push_back(predict_drive(t));
    end
    ticks_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    drive_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.drive_x = m_axis_tdata[DriveW-1:0];
      got.drive_y = m_axis_tdata[2*DriveW-1:DriveW];
      got.holding = m_axis_tdata[2*DriveW];
      results_seen++;
      if (got.holding) holds_seen++;
      if (pending_drives.size() == 0) begin
        $error("result beat with no tick awaiting it: drive_x %0d drive_y %0d holding %0b",
               got.drive_x, got.drive_y, got.holding);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        if (got.drive_x !== want.drive_x) begin
          $error("drive_x: expected %0d, got %0d", want.drive_x, got.drive_x);
          mismatches++;
        end
        if (got.drive_y !== want.drive_y) begin
          $error("drive_y: expected %0d, got %0d", want.drive_y, got.drive_y);
          mismatches++;
        end
        if (got.holding !== want.holding) begin
          $error("holding: expected %0b, got %0b", want.holding, got.holding);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        offer_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == 0) begin
        write_reg(p2p_pid_pkg::CFG_GAIN_P, p2p_pid_pkg::GainPRst);
        write_reg(p2p_pid_pkg::CFG_GAIN_I, p2p_pid_pkg::GainIRst);
        write_reg(p2p_pid_pkg::CFG_GAIN_D, pick_reg());
        write_reg(p2p_pid_pkg::CFG_OUTPUT_LIMIT, p2p_pid_pkg::LimitRst);
        write_reg(p2p_pid_pkg::CFG_NEAR_RADIUS, p2p_pid_pkg::RadiusRst);
      end else begin
        write_reg(p2p_pid_pkg::CFG_GAIN_P, pick_reg());
        write_reg(p2p_pid_pkg::CFG_GAIN_I, pick_reg());
        write_reg(p2p_pid_pkg::CFG_GAIN_D, pick_reg());
        write_reg(p2p_pid_pkg::CFG_OUTPUT_LIMIT, pick_reg());
        write_reg(p2p_pid_pkg::CFG_NEAR_RADIUS, pick_reg());
        write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1,
                                          p2p_pid_pkg::CFG_NEAR_RADIUS + 1)),
                  pick_reg());
      end
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      for (int k = 0; k < PhaseTicks; k++) begin
        // The receiver holds off while ticks keep coming, so the pipeline backs up.
        if (p == 0 && k == 40) hold_requests++;
        // The sender waits for the pipeline to run dry before going on.
        if (p == 1 && k == PhaseTicks / 2) settle();
        offer_tick(random_tick(), 1'b0, NoDrive);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d control ticks with %0d register writes, under stalls and a hold-off;",
             ticks_sent, reg_writes);
    $display("%0d drive results compared, %0d of them inside the arrival radius.",
             results_seen, holds_seen);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
